>>> sv/positional_ordered_list_core_macros.svh
// ----------------------------------------------------------------------------
// positional_ordered_list_core_macros.svh
// Assertion macros shared by the list core RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_CORE_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define POL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types and constants of the positional ordered list core.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4,
        REQ_REMOVE     = 3'd5,
        REQ_READOUT    = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        STAT_DONE  = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_NONE  = 3'd2,
        STAT_ENTRY = 3'd3,
        STAT_EMPTY = 3'd4
    } stat_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] at;
        logic [IDX_W-1:0] last_at;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } pol_state_t;

endpackage

>>> sv/pol_if.sv
// ----------------------------------------------------------------------------
// pol_if
// Request and response channels of the positional ordered list core.
// ----------------------------------------------------------------------------
interface pol_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] item_value;
    logic [7:0]         slot_position;

    modport source (output valid, req_type, item_value, slot_position, input ready);
    modport sink   (input valid, req_type, item_value, slot_position, output ready);
endinterface

interface pol_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [5:0]         entry_index;
    logic [6:0]         entry_count;
    logic               last;

    modport source (output valid, status, entry_value, entry_index, entry_count, last,
                    input ready);
    modport sink   (input valid, status, entry_value, entry_index, entry_count, last,
                    output ready);
endinterface

>>> sv/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One slot of the list: shifts towards either neighbour, takes a new value or the head value, or holds.
// ----------------------------------------------------------------------------
module pol_cell
    import pol_pkg::*;
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        cell_idx,
    input  cell_ctrl_t              ctrl,
    input  logic signed [VAL_W-1:0] ins_value,
    input  logic signed [VAL_W-1:0] prev_value,
    input  logic signed [VAL_W-1:0] next_value,
    input  logic signed [VAL_W-1:0] head_value,
    output logic signed [VAL_W-1:0] value
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (cell_idx == ctrl.at)
                    value_next = ins_value;
                else if (cell_idx > ctrl.at)
                    value_next = prev_value;
            end
            CELL_DELETE:
            begin
                if (cell_idx >= ctrl.at)
                    value_next = next_value;
            end
            CELL_ROTATE:
            begin
                if (cell_idx == ctrl.last_at)
                    value_next = head_value;
                else if (cell_idx < ctrl.last_at)
                    value_next = next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> sv/positional_ordered_list_core.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_core
// Bounded ordered list of signed words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready); results leave on rsp (valid/ready).
// Every request except readout gives one status item, registered on rsp
// in the cycle after acceptance; a new request is taken in the next cycle
// unless rsp stalls. Inserts and removals at any position take effect
// with that item: every cell loads from its left or right neighbour in parallel.
// Readout of n entries gives n items, one per cycle while rsp is not
// stalled, the first registered in the cycle after acceptance; the chain
// rotates by one slot per item, so the list is back in place after the
// last one. req.ready stays low until then. An empty readout gives one item.
// Reset empties the list; cell contents are left as they are.
// A stalled receiver holds the output register; req.ready drops until the
// pending item is taken, and readout pauses without losing its place.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_core_macros.svh"

module positional_ordered_list_core
    import pol_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pol_req_if.sink   req,
    pol_rsp_if.source rsp
);

    logic signed [VAL_W-1:0] cell_value [CAPACITY];
    cell_ctrl_t              ctrl;

    pol_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    logic               out_valid_reg, out_valid_next;
    stat_t              status_reg, status_next;
    logic signed [31:0] value_reg, value_next;
    logic [5:0]         index_reg, index_next;
    logic [6:0]         count_reg, count_next;
    logic               last_reg, last_next;

    logic             slot_free;
    logic             accept;
    logic             full;
    logic             empty;
    logic [LEN_W-1:0] pos_c;
    logic [LEN_W-1:0] len_m1;
    stat_t            st;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign full      = (len_reg == LEN_W'(CAPACITY));
    assign empty     = (len_reg == '0);
    assign len_m1    = len_reg - LEN_W'(1);

    always_comb
    begin
        if (req.slot_position == 8'd0)
            pos_c = LEN_W'(1);
        else if (req.slot_position > 8'(len_reg))
            pos_c = len_reg;
        else
            pos_c = LEN_W'(req.slot_position);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [VAL_W-1:0] prev_v;
            logic signed [VAL_W-1:0] next_v;
            if (g == 0)
            begin : g_first
                assign prev_v = '0;
            end
            else
            begin : g_prev
                assign prev_v = cell_value[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign next_v = '0;
            end
            else
            begin : g_next
                assign next_v = cell_value[g+1];
            end
            pol_cell u_cell (
                .clk        (clk),
                .cell_idx   (IDX_W'(g)),
                .ctrl       (ctrl),
                .ins_value  (req.item_value),
                .prev_value (prev_v),
                .next_value (next_v),
                .head_value (cell_value[0]),
                .value      (cell_value[g])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.op        = CELL_HOLD;
        ctrl.at        = '0;
        ctrl.last_at   = IDX_W'(len_m1);
        len_next       = len_reg;
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        st             = STAT_DONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    value_next     = '0;
                    index_next     = '0;
                    last_next      = 1'b1;
                    unique case (req.req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT:
                        begin
                            if (full)
                                st = STAT_FULL;
                            else
                            begin
                                ctrl.op  = CELL_INSERT;
                                len_next = len_reg + LEN_W'(1);
                                if (req.req_type == REQ_PUSH_FRONT)
                                    ctrl.at = '0;
                                else if (req.req_type == REQ_PUSH_BACK || empty)
                                    ctrl.at = IDX_W'(len_reg);
                                else
                                    ctrl.at = IDX_W'(pos_c);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            if (empty)
                                st = STAT_NONE;
                            else
                            begin
                                ctrl.op  = CELL_DELETE;
                                ctrl.at  = (req.req_type == REQ_POP_FRONT) ? '0
                                                                         : IDX_W'(len_m1);
                                len_next = len_m1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (empty || pos_c >= len_reg)
                                st = STAT_NONE;
                            else
                            begin
                                ctrl.op  = CELL_DELETE;
                                ctrl.at  = IDX_W'(pos_c);
                                len_next = len_m1;
                            end
                        end
                        REQ_READOUT:
                        begin
                            if (empty)
                                st = STAT_EMPTY;
                            else
                            begin
                                st         = STAT_ENTRY;
                                ctrl.op    = CELL_ROTATE;
                                value_next = cell_value[0];
                                last_next  = (len_reg == LEN_W'(1));
                                if (len_reg != LEN_W'(1))
                                begin
                                    state_next  = S_READ;
                                    rd_idx_next = IDX_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            st = STAT_DONE;
                        end
                    endcase
                    status_next = st;
                    count_next  = 7'(len_next);
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    ctrl.op        = CELL_ROTATE;
                    out_valid_next = 1'b1;
                    status_next    = STAT_ENTRY;
                    value_next     = cell_value[0];
                    index_next     = 6'(rd_idx_reg);
                    count_next     = 7'(len_reg);
                    last_next      = (rd_idx_reg == IDX_W'(len_m1));
                    rd_idx_next    = rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == IDX_W'(len_m1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        index_reg  <= index_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_value = value_reg;
    assign rsp.entry_index = index_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.last        = last_reg;

    `POL_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(CAPACITY), "list length over capacity")
    `POL_ASSERT_NOW(a_read_blocks, state_reg == S_READ, !req.ready, "request taken during readout")
    `POL_ASSERT_NOW(a_last_index, rsp.valid && rsp.last && rsp.status == STAT_ENTRY,
                    7'(rsp.entry_index) + 7'd1 == rsp.entry_count,
                    "last listed item index mismatch")
    `POL_ASSERT_NEXT(a_read_len_stable, state_reg == S_READ, len_reg == $past(len_reg),
                     "length changed during readout")

endmodule

>>> test/tb_positional_ordered_list_core.sv
// ----------------------------------------------------------------------------
// tb_positional_ordered_list_core
// Self-checking bench for the positional ordered list core.
// ----------------------------------------------------------------------------
// A queue of requests drives the req channel: first a short directed list,
// then random fill and drain phases. A shadow list predicts every result
// item at acceptance. The monitor compares each rsp item against the
// oldest awaited result. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list_core;
    import pol_pkg::*;

    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam int         N_RANDOM   = 480;
    localparam int         CALM_FROM  = 430;

    typedef struct {
        logic [2:0]         code;
        logic signed [31:0] value;
        logic [7:0]         pos;
        int                 gap;
        bit                 hold;
        bit                 calm;
    } list_req_t;

    typedef struct {
        stat_t              status;
        logic signed [31:0] value;
        logic [5:0]         index;
        logic [6:0]         count;
        logic               last;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    pol_req_if req_ch ();
    pol_rsp_if rsp_ch ();

    positional_ordered_list_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_req_t          queued_requests[$];
    list_req_t          head_req;
    logic signed [31:0] shadow_list[$];
    list_rsp_t          awaited_results[$];
    int                 mismatches = 0;
    logic               drained;
    logic               calm;
    logic               stall_phase;
    int                 stall_left;

    function automatic void apply_request(logic [2:0] code, logic signed [31:0] v,
                                          logic [7:0] pos);
        list_rsp_t r;
        int        n;
        int        p;
        n = shadow_list.size();
        p = (pos < 1) ? 1 : ((pos > n) ? n : int'(pos));
        r.status = STAT_DONE;
        r.value  = '0;
        r.index  = '0;
        r.last   = 1'b1;
        case (code)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT:
                if (n >= CAPACITY)
                    r.status = STAT_FULL;
                else if (code == REQ_PUSH_FRONT)
                    shadow_list.push_front(v);
                else if (code == REQ_PUSH_BACK || n == 0)
                    shadow_list.push_back(v);
                else
                    shadow_list.insert(p, v);
            REQ_POP_FRONT:
                if (n == 0)
                    r.status = STAT_NONE;
                else
                    void'(shadow_list.pop_front());
            REQ_POP_BACK:
                if (n == 0)
                    r.status = STAT_NONE;
                else
                    void'(shadow_list.pop_back());
            REQ_REMOVE:
                if (n == 0 || p >= n)
                    r.status = STAT_NONE;
                else
                    shadow_list.delete(p);
            REQ_READOUT:
                if (n == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.status = STAT_ENTRY;
                        r.value  = shadow_list[i];
                        r.index  = i[5:0];
                        r.count  = n[6:0];
                        r.last   = (i == n - 1);
                        awaited_results.push_back(r);
                    end
                    return;
                end
            default: ;
        endcase
        r.count = 7'(shadow_list.size());
        awaited_results.push_back(r);
    endfunction

    task automatic compare_result();
        list_rsp_t e;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: st=%0d val=%0d idx=%0d cnt=%0d last=%0b",
                         rsp_ch.status, rsp_ch.entry_value, rsp_ch.entry_index,
                         rsp_ch.entry_count, rsp_ch.last);
            return;
        end
        e = awaited_results.pop_front();
        if (rsp_ch.status !== e.status || rsp_ch.entry_value !== e.value ||
            rsp_ch.entry_index !== e.index || rsp_ch.entry_count !== e.count ||
            rsp_ch.last !== e.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp st=%0d val=%0d idx=%0d cnt=%0d last=%0b,",
                         e.status, e.value, e.index, e.count, e.last,
                         " got st=%0d val=%0d idx=%0d cnt=%0d last=%0b",
                         rsp_ch.status, rsp_ch.entry_value, rsp_ch.entry_index,
                         rsp_ch.entry_count, rsp_ch.last);
        end
    endtask

    function automatic void queue_request(logic [2:0] code, logic signed [31:0] v,
                                          logic [7:0] pos, int gap, bit hold, bit quiet);
        list_req_t q;
        q.code  = code;
        q.value = v;
        q.pos   = pos;
        q.gap   = gap;
        q.hold  = hold;
        q.calm  = quiet;
        queued_requests.push_back(q);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, CAPACITY + 1));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.req_type      <= '0;
            req_ch.item_value    <= '0;
            req_ch.slot_position <= '0;
            calm                 <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (queued_requests.size() == 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else if (queued_requests[0].gap > 0)
            begin
                req_ch.valid <= 1'b0;
                queued_requests[0].gap = queued_requests[0].gap - 1;
            end
            else if (queued_requests[0].hold && (req_ch.valid || !drained))
            begin
                req_ch.valid <= 1'b0;
            end
            else
            begin
                head_req              = queued_requests.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.req_type      <= head_req.code;
                req_ch.item_value    <= head_req.value;
                req_ch.slot_position <= head_req.pos;
                calm                 <= head_req.calm;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            stall_phase  <= 1'b0;
            drained      <= 1'b1;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                compare_result();
            if (req_ch.valid && req_ch.ready)
                apply_request(req_ch.req_type, req_ch.item_value, req_ch.slot_position);
            drained <= (awaited_results.size() == 0);
            if ($urandom_range(0, 63) == 0)
                stall_phase <= !stall_phase;
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (!calm && stall_phase && $urandom_range(0, 9) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 11);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        bit         filling;
        bit         idle_on;
        int         phase_left;
        int         roll;
        int         gap;
        bit         quiet;
        logic [2:0] code;

        rst_n = 1'b0;

        // directed: empty list corners, clamping at both ends, unused code
        queue_request(REQ_READOUT,    '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_POP_FRONT,  '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_POP_BACK,   '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_REMOVE,     '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_UNUSED,     -32'sd1,        8'd255, 0, 1'b0, 1'b0);
        queue_request(REQ_INSERT,     32'sh7fff_ffff, 8'd255, 0, 1'b0, 1'b0);
        queue_request(REQ_PUSH_FRONT, 32'sh8000_0000, 8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_PUSH_BACK,  -32'sd1,        8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_INSERT,     '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_INSERT,     32'sh5555_5555, 8'd255, 0, 1'b0, 1'b0);
        queue_request(REQ_INSERT,     32'shaaaa_aaaa, 8'd2,   0, 1'b0, 1'b0);
        queue_request(REQ_READOUT,    '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_REMOVE,     '0,             8'd255, 0, 1'b0, 1'b0);
        queue_request(REQ_REMOVE,     '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_REMOVE,     '0,             8'd1,   0, 1'b0, 1'b0);
        queue_request(REQ_UNUSED,     '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_POP_FRONT,  '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_POP_BACK,   '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_READOUT,    '0,             8'd0,   0, 1'b0, 1'b0);
        queue_request(REQ_REMOVE,     '0,             8'd1,   0, 1'b1, 1'b0);
        queue_request(REQ_READOUT,    '0,             8'd0,   0, 1'b0, 1'b0);

        // random: alternating fill and drain phases, fill first to reach full
        filling    = 1'b1;
        idle_on    = 1'b0;
        phase_left = 40;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                idle_on    = $urandom_range(0, 2) != 0;
                phase_left = $urandom_range(20, 50);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                code = REQ_UNUSED;
            else if (roll < 12)
                code = REQ_READOUT;
            else if ((roll < 72) == filling)
                code = 3'($urandom_range(REQ_PUSH_FRONT, REQ_INSERT));
            else
                code = 3'($urandom_range(REQ_POP_FRONT, REQ_REMOVE));
            quiet = (i >= CALM_FROM);
            gap   = (!quiet && idle_on && $urandom_range(0, 4) == 0) ?
                    $urandom_range(1, 12) : 0;
            queue_request(code, pick_value(), pick_position(), gap,
                          i == 60 || $urandom_range(0, 59) == 0, quiet);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (queued_requests.size() != 0 || req_ch.valid || !drained);
        repeat (2 * CAPACITY + 8) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
